@@ design/fbf_pkg.sv @@
// fbf_pkg: shared types, constants and the coefficient table of the band-stop fir
// holds the half coefficient set (q1.17), its mirror lookup and the sequencer states
// no dependencies

package fbf_pkg;

   localparam int SAMPLE_W = 12;
   localparam int FILT_W   = 12;
   localparam int TDATA_W  = 16;
   localparam int ROM_HALF = 151;
   localparam int ROM_LAST = 300;
   localparam int ROM_BITS = 18;

   localparam logic signed [ROM_BITS-1:0] COEF_HALF [0:ROM_HALF-1] = '{
      -18'sd45, -18'sd43, -18'sd37, -18'sd27, -18'sd14, 18'sd0, 18'sd15, 18'sd28,
      18'sd40, 18'sd48, 18'sd51, 18'sd50, 18'sd43, 18'sd32, 18'sd17, 18'sd0,
      -18'sd18, -18'sd35, -18'sd49, -18'sd58, -18'sd62, -18'sd60, -18'sd52, -18'sd38,
      -18'sd20, 18'sd0, 18'sd21, 18'sd40, 18'sd55, 18'sd65, 18'sd69, 18'sd65,
      18'sd55, 18'sd40, 18'sd21, 18'sd0, -18'sd20, -18'sd36, -18'sd48, -18'sd55,
      -18'sd54, -18'sd49, -18'sd38, -18'sd25, -18'sd12, 18'sd0, 18'sd9, 18'sd13,
      18'sd12, 18'sd7, 18'sd0, -18'sd8, -18'sd14, -18'sd16, -18'sd12, 18'sd0,
      18'sd19, 18'sd43, 18'sd69, 18'sd95, 18'sd114, 18'sd123, 18'sd118, 18'sd95,
      18'sd56, 18'sd0, -18'sd67, -18'sd139, -18'sd209, -18'sd266, -18'sd302, -18'sd309,
      -18'sd282, -18'sd219, -18'sd123, 18'sd0, 18'sd140, 18'sd282, 18'sd411, 18'sd511,
      18'sd567, 18'sd569, 18'sd509, 18'sd389, 18'sd214, 18'sd0, -18'sd235, -18'sd468,
      -18'sd672, -18'sd824, -18'sd903, -18'sd893, -18'sd790, -18'sd596, -18'sd325, 18'sd0,
      18'sd349, 18'sd686, 18'sd976, 18'sd1185, 18'sd1285, 18'sd1260, 18'sd1104, 18'sd826,
      18'sd446, 18'sd0, -18'sd471, -18'sd919, -18'sd1298, -18'sd1563, -18'sd1683,
      -18'sd1637, -18'sd1424, -18'sd1057, -18'sd567, 18'sd0, 18'sd590, 18'sd1145,
      18'sd1604, 18'sd1920, 18'sd2053, 18'sd1985, 18'sd1715, 18'sd1265, 18'sd675, 18'sd0,
      -18'sd694, -18'sd1337, -18'sd1863, -18'sd2215, -18'sd2355, -18'sd2264, -18'sd1945,
      -18'sd1427, -18'sd757, 18'sd0, 18'sd769, 18'sd1473, 18'sd2042, 18'sd2415,
      18'sd2553, 18'sd2441, 18'sd2086, 18'sd1521, 18'sd803, 18'sd0, -18'sd807,
      -18'sd1538, -18'sd2119, -18'sd2493, 18'sd128489
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } fbf_state_type;

   // marks one tap on its way through the multiply-accumulate pipe
   typedef struct packed {
      logic vld;
      logic first;
      logic last;
   } fbf_tap_ctl_type;

   // coefficient of tap k rescaled to q1.(cbits-1), sign extended to 32 bits
   function automatic logic signed [31:0] coef_scaled(input int k, input int cbits);
      logic signed [31:0] v;
      logic signed [31:0] mag;
      int m;
      if (k > ROM_LAST) begin
         v = '0;
      end else begin
         m = (k < ROM_HALF) ? k : ROM_LAST - k;
         v = 32'(COEF_HALF[m]);
         if (cbits >= ROM_BITS) begin
            v = v <<< (cbits - ROM_BITS);
         end else if (v < 0) begin
            // narrowing rounds toward zero
            mag = -v;
            mag = mag >>> (ROM_BITS - cbits);
            v = -mag;
         end else begin
            v = v >>> (ROM_BITS - cbits);
         end
      end
      return v;
   endfunction

endpackage

@@ design/fbf_mac.sv @@
// fbf_mac: multiply-accumulate pipe and output saturation of the band-stop fir
// one product register, one accumulator, done pulse after the last tap
// depends on fbf_pkg

module fbf_mac import fbf_pkg::*; #(
   parameter int SAMPLE_BITS = 12,
   parameter int COEF_BITS   = 18,
   parameter int ACC_BITS    = 40
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fbf_tap_ctl_type             tap_ctl,
   input  logic [SAMPLE_BITS-1:0]      tap_sample,
   input  logic signed [COEF_BITS-1:0] tap_coef,
   output logic                        done,
   output logic [FILT_W-1:0]           result
);

   localparam int PROD_BITS = SAMPLE_BITS + 1 + COEF_BITS;

   fbf_tap_ctl_type              ctl_ff;
   logic signed [PROD_BITS-1:0]  prod_ff;
   logic signed [PROD_BITS-1:0]  prod_in;
   logic signed [ACC_BITS-1:0]   acc_ff;
   logic signed [ACC_BITS-1:0]   acc_in;
   logic                         done_ff;
   logic [ACC_BITS-1:0]          quot;
   logic [ACC_BITS-1:0]          sat;

   localparam logic [ACC_BITS-1:0] SAT_MAX = ACC_BITS'((64'd1 << SAMPLE_BITS) - 64'd1);

   assign prod_in = $signed({1'b0, tap_sample}) * tap_coef;

   always_comb begin
      if (ctl_ff.first) begin
         acc_in = ACC_BITS'(prod_ff);
      end else begin
         acc_in = acc_ff + ACC_BITS'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         ctl_ff  <= tap_ctl;
         done_ff <= ctl_ff.vld && ctl_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (ctl_ff.vld) begin
         acc_ff <= acc_in;
      end
   end

   // negative sums clip to zero, so truncation toward zero is a plain shift here
   always_comb begin
      quot = $unsigned(acc_ff) >> (COEF_BITS - 1);
      if (acc_ff[ACC_BITS-1]) begin
         sat = '0;
      end else if (quot > SAT_MAX) begin
         sat = SAT_MAX;
      end else begin
         sat = quot;
      end
   end

   assign done   = done_ff;
   assign result = sat[FILT_W-1:0];

endmodule

@@ design/fir_bandstop_filter_top.sv @@
// fir_bandstop_filter_top: 45-55 hz band-stop direct-form fir, one sample in, one out
// circular delay line in a registered-read memory, coefficient table, mac pipe
// depends on fbf_pkg and fbf_mac
//
// usage:
//   req channel: one unsigned converter sample per word in req_tdata[11:0].
//   rsp channel: one filtered sample per word in rsp_tdata[11:0], saturated to
//   0 .. 2^SAMPLE_BITS-1 after truncation toward zero.
//   a sample is written into the delay memory when accepted; the sequencer then
//   reads one tap per cycle, newest first, and feeds the multiply-accumulate pipe.
//   the tap sweep is paced by the single memory read port and the one multiplier,
//   one tap a cycle.
//   req_tready is high only while the sequencer is idle, so a new sample is not
//   taken until the last sum has gone to the output register; it is taken even
//   while a result is waiting.
//   if rsp is stalled, the finished sum waits in the pipe until the output
//   register frees up; nothing is dropped.
//   reset clears the control state; a fill count makes delay entries never
//   written read as zero, so no clearing pass is needed.

module fir_bandstop_filter_top import fbf_pkg::*; #(
   parameter int TAPS        = 301,
   parameter int SAMPLE_BITS = 12,
   parameter int COEF_BITS   = 18
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,   // [11:0] sample, rest zero
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata    // [11:0] filtered, rest zero
);

   localparam int AW       = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int KW       = $clog2(TAPS + 1);
   localparam int ACC_BITS = SAMPLE_BITS + COEF_BITS + KW + 1;

   logic [SAMPLE_BITS-1:0] dline_mem [0:TAPS-1];

   fbf_state_type              state_ff, state_in;
   logic [AW-1:0]              head_ff, head_in;
   logic [AW-1:0]              ptr_ff, ptr_in;
   logic [KW-1:0]              tap_ff, tap_in;
   logic [KW-1:0]              fill_ff, fill_in;
   logic                       pending_ff, pending_in;
   logic                       rsp_vld_ff, rsp_vld_in;
   logic [FILT_W-1:0]          rsp_data_ff;
   logic                       load_rsp;
   logic                       accept;
   logic                       wr_en;
   logic [SAMPLE_BITS-1:0]     wr_data;

   fbf_tap_ctl_type             ctl1_ff, ctl1_in;
   logic                        live1_ff, live1_in;
   logic [SAMPLE_BITS-1:0]      rd_data_ff;
   logic signed [COEF_BITS-1:0] coef_ff, coef_in;
   logic [SAMPLE_BITS-1:0]      tap_sample;

   logic                        mac_done;
   logic [FILT_W-1:0]           mac_result;

   assign accept  = req_tvalid && req_tready;
   assign wr_data = SAMPLE_BITS'(req_tdata[SAMPLE_W-1:0]);
   assign coef_in = COEF_BITS'(coef_scaled(int'(tap_ff), COEF_BITS));

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      ptr_in     = ptr_ff;
      tap_in     = tap_ff;
      fill_in    = fill_ff;
      pending_in = pending_ff;
      rsp_vld_in = rsp_vld_ff;
      load_rsp   = 1'b0;
      wr_en      = 1'b0;
      req_tready = 1'b0;
      ctl1_in    = '0;
      live1_in   = 1'b0;

      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               head_in  = (head_ff == AW'(TAPS - 1)) ? '0 : head_ff + 1'b1;
               ptr_in   = head_in;
               wr_en    = 1'b1;
               tap_in   = '0;
               if (fill_ff != KW'(TAPS)) begin
                  fill_in = fill_ff + 1'b1;
               end
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            ctl1_in.vld   = 1'b1;
            ctl1_in.first = (tap_ff == '0);
            ctl1_in.last  = (tap_ff == KW'(TAPS - 1));
            // taps older than anything written since reset read as zero
            live1_in      = (tap_ff < fill_ff);
            tap_in        = tap_ff + 1'b1;
            ptr_in        = (ptr_ff == '0) ? AW'(TAPS - 1) : ptr_ff - 1'b1;
            if (ctl1_in.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mac_done || pending_ff) begin
               if (!rsp_vld_ff || rsp_tready) begin
                  load_rsp   = 1'b1;
                  rsp_vld_in = 1'b1;
                  pending_in = 1'b0;
                  state_in   = ST_IDLE;
               end else begin
                  pending_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         head_ff    <= '0;
         ptr_ff     <= '0;
         tap_ff     <= '0;
         fill_ff    <= '0;
         pending_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         ctl1_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         ptr_ff     <= ptr_in;
         tap_ff     <= tap_in;
         fill_ff    <= fill_in;
         pending_ff <= pending_in;
         rsp_vld_ff <= rsp_vld_in;
         ctl1_ff    <= ctl1_in;
      end
   end

   // delay memory: one write on accept, one registered read per tap
   always_ff @(posedge clock) begin
      if (wr_en) begin
         dline_mem[head_in] <= wr_data;
      end
      rd_data_ff <= dline_mem[ptr_ff];
   end

   always_ff @(posedge clock) begin
      live1_ff <= live1_in;
      coef_ff  <= coef_in;
      if (load_rsp) begin
         rsp_data_ff <= mac_result;
      end
   end

   assign tap_sample = live1_ff ? rd_data_ff : '0;

   fbf_mac #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS),
      .ACC_BITS    (ACC_BITS)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .tap_ctl    (ctl1_ff),
      .tap_sample (tap_sample),
      .tap_coef   (coef_ff),
      .done       (mac_done),
      .result     (mac_result)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = TDATA_W'(rsp_data_ff);

   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> state_ff == ST_DRAIN)
      else $error("mac finished outside drain");

   a_done_not_pending: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> !pending_ff)
      else $error("second sum finished while one still pending");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= KW'(TAPS))
      else $error("fill count beyond tap count");

   a_accept_starts_run: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_RUN && tap_ff == '0 && ptr_ff == head_ff)
      else $error("tap sweep did not start at newest sample");

endmodule
